// File: hw/rtl/ubd_pkg.sv
// shared types, constants and rounding helper for the baud divider calculator
package ubd_pkg;

  localparam int CLK_W    = 28;
  localparam int BAUD_W   = 24;
  localparam int NUM_W    = 33;                 // width of 25 * clock
  localparam int DIV_W    = BAUD_W + 2;         // 4 * baud at most
  localparam int MANT_W   = 12;
  localparam int RES_W    = 7;                  // residue modulo 100
  localparam int FRAC_W   = 4;
  localparam int WORD_W   = 16;
  localparam int LATENCY  = NUM_W + 1;          // division cells plus finish stage

  localparam logic [7:0]  MOD_BASE    = 8'd100;
  localparam logic [10:0] ROUND_HALF  = 11'd50;
  localparam logic [10:0] RECIP_100   = 11'd1311;  // 2^17 / 100, rounded up
  localparam int          RECIP_SHIFT = 17;
  localparam logic [MANT_W-1:0] MANT_MAX = '1;

  typedef struct packed {
    logic              zero;
    logic              by8;
    logic [NUM_W-1:0]  num;
    logic [DIV_W-1:0]  div;
    logic [DIV_W-1:0]  part;
    logic [RES_W-1:0]  res;
    logic [MANT_W-1:0] mant;
    logic              ovf;
  } ubd_data_t;

  // rounded fraction (res * 8 or 16 + 50) / 100, masked to 3 or 4 bits
  function automatic logic [FRAC_W-1:0] frac_round(input logic [RES_W-1:0] res,
                                                   input logic by8);
    logic [10:0] x;
    logic [21:0] p;
    logic [4:0]  q;
    x = by8 ? ({1'b0, res, 3'b000} + ROUND_HALF) : ({res, 4'b0000} + ROUND_HALF);
    p = {11'd0, x} * {11'd0, RECIP_100};
    q = p[RECIP_SHIFT+4:RECIP_SHIFT];
    return by8 ? {1'b0, q[2:0]} : q[3:0];
  endfunction

endpackage

// File: hw/rtl/ubd_cell.sv
// one restoring division step with running quotient-by-100 tracking
module ubd_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ubd_pkg::ubd_data_t in_data,
  output logic               out_valid,
  output ubd_pkg::ubd_data_t out_data
);

  logic [ubd_pkg::DIV_W:0]   trial;
  logic                      qbit;
  logic [ubd_pkg::DIV_W:0]   diff;
  logic [ubd_pkg::RES_W:0]   r2;
  logic                      mbit;
  logic [ubd_pkg::RES_W:0]   r2_sub;
  ubd_pkg::ubd_data_t        data_next;

  always_comb begin
    trial  = {in_data.part, in_data.num[ubd_pkg::NUM_W-1]};
    qbit   = trial >= {1'b0, in_data.div};
    diff   = trial - {1'b0, in_data.div};
    // quotient bit enters a long division by 100
    r2     = {in_data.res, qbit};
    mbit   = r2 >= ubd_pkg::MOD_BASE;
    r2_sub = r2 - ubd_pkg::MOD_BASE;

    data_next      = in_data;
    data_next.num  = {in_data.num[ubd_pkg::NUM_W-2:0], 1'b0};
    data_next.part = qbit ? diff[ubd_pkg::DIV_W-1:0] : trial[ubd_pkg::DIV_W-1:0];
    data_next.res  = mbit ? r2_sub[ubd_pkg::RES_W-1:0] : r2[ubd_pkg::RES_W-1:0];
    data_next.mant = {in_data.mant[ubd_pkg::MANT_W-2:0], mbit};
    data_next.ovf  = in_data.ovf | in_data.mant[ubd_pkg::MANT_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

// File: hw/rtl/ubd_finish.sv
// fraction rounding, saturation and result register
module ubd_finish (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  ubd_pkg::ubd_data_t          in_data,
  output logic                        done,
  output logic [ubd_pkg::WORD_W-1:0]  divider_word,
  output logic                        mantissa_saturated,
  output logic                        zero_baud_error
);

  logic [ubd_pkg::FRAC_W-1:0] frac;
  logic [ubd_pkg::MANT_W-1:0] mant;
  logic [ubd_pkg::WORD_W-1:0] word_next;
  logic                       sat_next;

  always_comb begin
    frac      = ubd_pkg::frac_round(in_data.res, in_data.by8);
    mant      = in_data.ovf ? ubd_pkg::MANT_MAX : in_data.mant;
    word_next = in_data.zero ? '0 : {mant, frac};
    sat_next  = in_data.ovf & ~in_data.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    divider_word       <= word_next;
    mantissa_saturated <= sat_next;
    zero_baud_error    <= in_data.zero;
  end

endmodule

// File: hw/rtl/uart_baud_divider_calc_top.sv
// top level of the uart baud divider calculator
//
// a request is transferred at a rising edge with start high and busy low;
// busy is high only while rst is asserted, so one request is taken per cycle
// each request carries clock_hz, baud_rate and oversample_by_8
// the result (divider_word, mantissa_saturated, zero_baud_error) shows for
// exactly one cycle with done high
// the receiver cannot stall: done is a single-cycle strobe
// 25 * clock is divided by 2 * baud (by 8) or 4 * baud (by 16) in a chain
// of 33 cells, one quotient bit per cell, each cell also folding its bit
// into a running division by 100 that yields mantissa and remainder
// a finish stage rounds the remainder into the fraction and clamps the
// mantissa to 12 bits
// each request passes the 33 division cells and then the output
// register; throughput is one request per cycle
// rst clears the valid bits of the chain and done; requests in flight are
// dropped
module uart_baud_divider_calc_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [ubd_pkg::CLK_W-1:0]   clock_hz,
  input  logic [ubd_pkg::BAUD_W-1:0]  baud_rate,
  input  logic                        oversample_by_8,
  output logic                        done,
  output logic [ubd_pkg::WORD_W-1:0]  divider_word,
  output logic                        mantissa_saturated,
  output logic                        zero_baud_error
);

  localparam int NCELL = ubd_pkg::NUM_W;

  logic               valid [0:NCELL];
  ubd_pkg::ubd_data_t data  [0:NCELL];
  ubd_pkg::ubd_data_t head;
  logic [ubd_pkg::NUM_W-1:0] clk_ext;

  assign busy     = rst;
  assign valid[0] = start & ~busy;
  assign data[0]  = head;

  // 25 * clock as a shift-and-add
  always_comb begin
    clk_ext    = {{(ubd_pkg::NUM_W-ubd_pkg::CLK_W){1'b0}}, clock_hz};
    head.zero  = baud_rate == '0;
    head.by8   = oversample_by_8;
    head.num   = (clk_ext << 4) + (clk_ext << 3) + clk_ext;
    head.div   = oversample_by_8 ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};
    head.part  = '0;
    head.res   = '0;
    head.mant  = '0;
    head.ovf   = 1'b0;
  end

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ubd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_data   (data[i]),
      .out_valid (valid[i+1]),
      .out_data  (data[i+1])
    );
  end

  ubd_finish u_finish (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (valid[NCELL]),
    .in_data            (data[NCELL]),
    .done               (done),
    .divider_word       (divider_word),
    .mantissa_saturated (mantissa_saturated),
    .zero_baud_error    (zero_baud_error)
  );

endmodule

// File: hw/rtl/ubd_checker.sv
// port-level checks for the baud divider calculator, bound to the top level
module ubd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic [ubd_pkg::BAUD_W-1:0]  baud_rate,
  input logic                        oversample_by_8,
  input logic                        done,
  input logic [ubd_pkg::WORD_W-1:0]  divider_word,
  input logic                        mantissa_saturated,
  input logic                        zero_baud_error
);

  localparam int LAT = ubd_pkg::LATENCY;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("result strobe missing after request transfer");

  a_zero_baud: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && baud_rate == '0) |-> ##LAT (done && zero_baud_error))
    else $error("zero baud not flagged");

  a_zero_word: assert property (@(posedge clk) disable iff (rst)
    (done && zero_baud_error) |-> (divider_word == '0 && !mantissa_saturated))
    else $error("zero baud result not cleared");

  a_by8_frac: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && oversample_by_8) |-> ##LAT (divider_word[3] == 1'b0))
    else $error("fraction bit 3 set when oversampling by 8");

endmodule

bind uart_baud_divider_calc_top ubd_checker u_ubd_checker (
  .clk                (clk),
  .rst                (rst),
  .start              (start),
  .busy               (busy),
  .baud_rate          (baud_rate),
  .oversample_by_8    (oversample_by_8),
  .done               (done),
  .divider_word       (divider_word),
  .mantissa_saturated (mantissa_saturated),
  .zero_baud_error    (zero_baud_error)
);

// File: verif/tb_uart_baud_divider_calc_top.sv
// self-checking testbench for the uart baud divider calculator
module tb_uart_baud_divider_calc_top;

  // one request as it goes to the block
  typedef struct {
    logic [ubd_pkg::CLK_W-1:0]  clock_hz;
    logic [ubd_pkg::BAUD_W-1:0] baud_rate;
    logic                       by8;
  } baud_request_t;

  // one divider result as it leaves the block
  typedef struct {
    logic [ubd_pkg::WORD_W-1:0] word;
    logic                       saturated;
    logic                       zero_baud;
  } divider_result_t;

  localparam int RANDOM_ITEMS   = 1200;
  localparam int QUIET_TAIL     = 200;   // last requests go out with no gaps
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with neither a transfer nor a result
  localparam int MAX_REPORTS    = 10;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic [ubd_pkg::CLK_W-1:0]  clock_hz = '0;
  logic [ubd_pkg::BAUD_W-1:0] baud_rate = '0;
  logic                       oversample_by_8 = 1'b0;
  logic                       done;
  logic [ubd_pkg::WORD_W-1:0] divider_word;
  logic                       mantissa_saturated;
  logic                       zero_baud_error;

  baud_request_t   pending_requests[$];
  divider_result_t expected_dividers[$];

  int issued_cnt   = 0;  // requests put on the ports
  int taken_cnt    = 0;  // requests transferred into the block
  int gap_left     = 0;
  int mismatch_cnt = 0;
  int quiet_cycles = 0;

  uart_baud_divider_calc_top u_dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .clock_hz           (clock_hz),
    .baud_rate          (baud_rate),
    .oversample_by_8    (oversample_by_8),
    .done               (done),
    .divider_word       (divider_word),
    .mantissa_saturated (mantissa_saturated),
    .zero_baud_error    (zero_baud_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // usartdiv scaled by 100, split into mantissa and rounded fraction;
  // the rounding carry is masked off and never reaches the mantissa
  function automatic divider_result_t predict_divider(baud_request_t req);
    divider_result_t   res;
    longint unsigned   scaled;
    longint unsigned   mant;
    longint unsigned   rem;
    longint unsigned   frac;
    longint unsigned   word;
    res.word      = '0;
    res.saturated = 1'b0;
    res.zero_baud = 1'b0;
    if (req.baud_rate == 0) begin
      res.zero_baud = 1'b1;
      return res;
    end
    if (req.by8) begin
      scaled = (64'd25 * req.clock_hz) / (64'd2 * req.baud_rate);
    end else begin
      scaled = (64'd25 * req.clock_hz) / (64'd4 * req.baud_rate);
    end
    mant = scaled / 100;
    rem  = scaled - mant * 100;
    if (req.by8) begin
      frac = ((rem * 8 + 50) / 100) & 64'h7;
    end else begin
      frac = ((rem * 16 + 50) / 100) & 64'hF;
    end
    if (mant > 64'(ubd_pkg::MANT_MAX)) begin
      mant          = 64'(ubd_pkg::MANT_MAX);
      res.saturated = 1'b1;
    end
    word     = (mant << 4) | frac;
    res.word = word[ubd_pkg::WORD_W-1:0];
    return res;
  endfunction

  task automatic queue_request(input longint unsigned clk_hz, input longint unsigned baud,
                               input bit by8);
    baud_request_t req;
    req.clock_hz  = clk_hz[ubd_pkg::CLK_W-1:0];
    req.baud_rate = baud[ubd_pkg::BAUD_W-1:0];
    req.by8       = by8;
    pending_requests.push_back(req);
  endtask

  // random request drawn from a few families so that saturation, realistic
  // settings, tiny mantissas and near-carry fractions all show up
  task automatic queue_random_request();
    int unsigned     kind;
    bit              by8;
    longint unsigned clk_hz;
    longint unsigned baud;
    longint unsigned target;
    kind = $urandom_range(99, 0);
    by8  = 1'($urandom_range(1, 0));
    if (kind < 35) begin
      // typical bus clocks and baud rates
      clk_hz = 64'($urandom_range(171798691, 1000000));
      baud   = 64'($urandom_range(4000000, 300));
    end else if (kind < 55) begin
      // any bit pattern on both fields
      clk_hz = 64'($urandom() & 32'h0FFF_FFFF);
      baud   = 64'($urandom() & 32'h00FF_FFFF);
    end else if (kind < 70) begin
      // tiny baud, mantissa mostly clamped
      clk_hz = 64'($urandom() & 32'h0FFF_FFFF);
      baud   = 64'($urandom_range(255, 1));
    end else if (kind < 92) begin
      // aim at a chosen mantissa and remainder, near the clamp and the carry
      baud   = 64'($urandom_range(65535, 1));
      target = 64'($urandom_range(4200, 0)) * 100 + 64'($urandom_range(99, 0));
      clk_hz = (target * (by8 ? 64'd2 : 64'd4) * baud + 24) / 25;
      if (clk_hz > 64'h0FFF_FFFF) begin
        clk_hz = 64'($urandom() & 32'h0FFF_FFFF);
      end
    end else if (kind < 96) begin
      // zero baud
      clk_hz = 64'($urandom() & 32'h0FFF_FFFF);
      baud   = 0;
    end else begin
      // stopped clock
      clk_hz = 0;
      baud   = 64'($urandom() & 32'h00FF_FFFF);
    end
    queue_request(clk_hz, baud, by8);
  endtask

  // driver: changes inputs on the falling edge, takes the next request once
  // the one on the ports has been transferred, with random gaps in between
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && taken_cnt != issued_cnt) begin
      // request still waiting for its transfer, hold it
    end else if (gap_left > 0) begin
      start    <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_requests.size() == 0) begin
      start <= 1'b0;
    end else if (pending_requests.size() > QUIET_TAIL && ((issued_cnt / 100) % 3 != 2) &&
                 $urandom_range(5, 0) == 0) begin
      // gap burst with start low, this cycle included, the rest counted in gap_left
      start    <= 1'b0;
      gap_left = $urandom_range(11, 1) - 1;
    end else begin
      clock_hz        <= pending_requests[0].clock_hz;
      baud_rate       <= pending_requests[0].baud_rate;
      oversample_by_8 <= pending_requests[0].by8;
      start           <= 1'b1;
      void'(pending_requests.pop_front());
      issued_cnt = issued_cnt + 1;
    end
  end

  // monitor: samples on the rising edge, checks results against the oldest
  // expectation and records each request transfer with its prediction
  always @(posedge clk) begin
    baud_request_t   req;
    divider_result_t exp_res;
    if (!rst) begin
      quiet_cycles = quiet_cycles + 1;
      if (done) begin
        quiet_cycles = 0;
        if (expected_dividers.size() == 0) begin
          if (mismatch_cnt < MAX_REPORTS) begin
            $display("unexpected result: word %h sat %b zero_baud %b",
                     divider_word, mantissa_saturated, zero_baud_error);
          end
          mismatch_cnt = mismatch_cnt + 1;
        end else begin
          exp_res = expected_dividers.pop_front();
          if (divider_word !== exp_res.word || mantissa_saturated !== exp_res.saturated ||
              zero_baud_error !== exp_res.zero_baud) begin
            if (mismatch_cnt < MAX_REPORTS) begin
              $display("mismatch: word exp %h got %h, sat exp %b got %b, zero_baud exp %b got %b",
                       exp_res.word, divider_word, exp_res.saturated, mantissa_saturated,
                       exp_res.zero_baud, zero_baud_error);
            end
            mismatch_cnt = mismatch_cnt + 1;
          end
        end
      end
      if (start && !busy) begin
        quiet_cycles  = 0;
        req.clock_hz  = clock_hz;
        req.baud_rate = baud_rate;
        req.by8       = oversample_by_8;
        expected_dividers.push_back(predict_divider(req));
        taken_cnt = taken_cnt + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    // directed requests: field extremes, both modes, zero baud, stopped
    // clock, clamp boundary and fractions that round up to a full step
    queue_request(0, 0, 1'b0);
    queue_request(64'h0FFF_FFFF, 0, 1'b1);
    queue_request(0, 1, 1'b0);
    queue_request(0, 64'hFF_FFFF, 1'b1);
    queue_request(64'h0FFF_FFFF, 1, 1'b0);
    queue_request(64'h0FFF_FFFF, 1, 1'b1);
    queue_request(64'h0FFF_FFFF, 64'hFF_FFFF, 1'b0);
    queue_request(64'h0FFF_FFFF, 64'hFF_FFFF, 1'b1);
    queue_request(171798691, 1, 1'b0);
    queue_request(171798691, 9600, 1'b1);
    queue_request(65535, 1, 1'b0);         // mantissa just at the clamp
    queue_request(65536, 1, 1'b0);         // mantissa one past the clamp
    queue_request(32767, 1, 1'b1);
    queue_request(32768, 1, 1'b1);
    queue_request(223, 7, 1'b0);           // remainder 99 rounds to 16, masked to 0
    queue_request(111, 7, 1'b1);           // remainder 98 rounds to 8, masked to 0
    queue_request(16000000, 9600, 1'b0);
    queue_request(16000000, 115200, 1'b1);
    queue_request(84000000, 115200, 1'b0);
    queue_request(42000000, 921600, 1'b1);
    queue_request(8000000, 2400, 1'b0);
    queue_request(64'h0AAA_AAAA, 64'h55_5555, 1'b0);
    queue_request(64'h0555_5555, 64'hAA_AAAA, 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queue_random_request();
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every request to go in and every result to come back
    while (pending_requests.size() != 0 || taken_cnt != issued_cnt ||
           expected_dividers.size() != 0) begin
      @(posedge clk);
    end
    // let any stray result drain out of the pipeline
    repeat (ubd_pkg::LATENCY + 8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
